>>> sv/tpp_pkg.sv
// shared types and constants for the tape pulse playback block
package tpp_pkg;

  localparam int LENGTH_WIDTH_DEF = 26;

  localparam int SHORT_SCALE_W = 12;
  localparam int LONG_SCALE_W  = 10;
  localparam int BYTE_W        = 8;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 12;

  localparam logic [SHORT_SCALE_W-1:0] SHORT_SCALE_RST = 12'd2079;
  localparam logic [LONG_SCALE_W-1:0]  LONG_SCALE_RST  = 10'd260;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_SHORT_SCALE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LONG_SCALE  = 2'd1;

  // long-form byte sequencing, value is the number of bytes still expected
  typedef enum logic [1:0] {
    LF_NONE  = 2'd0,
    LF_LAST  = 2'd1,
    LF_MID   = 2'd2,
    LF_FIRST = 2'd3
  } long_phase_t;

  typedef struct packed {
    logic read_level;
    logic byte_taken;
    logic pulse_end;
  } tpp_result_t;

endpackage

>>> sv/tpp_scale.sv
// pulse length scaling: one shared multiplier, shift and saturation
module tpp_scale #(
  parameter int LENGTH_WIDTH = tpp_pkg::LENGTH_WIDTH_DEF
) (
  input  logic                                 long_sel,
  input  logic [tpp_pkg::BYTE_W-1:0]           data_byte,
  input  logic [tpp_pkg::BYTE_W-1:0]           long_byte0,
  input  logic [tpp_pkg::BYTE_W-1:0]           long_byte1,
  input  logic [tpp_pkg::SHORT_SCALE_W-1:0]    short_scale,
  input  logic [tpp_pkg::LONG_SCALE_W-1:0]     long_scale,
  output logic [LENGTH_WIDTH-1:0]              period
);

  localparam int AW = 3 * tpp_pkg::BYTE_W;
  localparam int BW = tpp_pkg::SHORT_SCALE_W;
  localparam int PW = AW + BW;
  localparam int SW = PW - 8;
  localparam int CW = (SW > LENGTH_WIDTH) ? SW : LENGTH_WIDTH;

  logic [AW-1:0] op_a;
  logic [BW-1:0] op_b;
  logic [PW-1:0] prod;
  logic [SW-1:0] scaled;
  logic [CW-1:0] scaled_ext;
  logic [CW-1:0] len_max_ext;

  always_comb begin
    if (long_sel) begin
      op_a = {data_byte, long_byte1, long_byte0};
      op_b = BW'(long_scale);
    end else begin
      op_a = AW'(data_byte);
      op_b = short_scale;
    end
    prod        = PW'(op_a) * PW'(op_b);
    scaled      = prod[PW-1:8];
    scaled_ext  = CW'(scaled);
    len_max_ext = CW'({LENGTH_WIDTH{1'b1}});
    if (scaled_ext > len_max_ext) begin
      period = {LENGTH_WIDTH{1'b1}};
    end else begin
      period = scaled_ext[LENGTH_WIDTH-1:0];
    end
  end

endmodule

>>> sv/tpp_pulse.sv
// pulse state: byte intake, long-form assembly, tick counting and line level
module tpp_pulse #(
  parameter int LENGTH_WIDTH = tpp_pkg::LENGTH_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               step,
  input  logic                               motor_on,
  input  logic                               data_valid,
  input  logic [tpp_pkg::BYTE_W-1:0]         data_byte,
  input  logic [tpp_pkg::SHORT_SCALE_W-1:0]  short_scale,
  input  logic [tpp_pkg::LONG_SCALE_W-1:0]   long_scale,
  output tpp_pkg::tpp_result_t               res
);

  logic                        busy_r, busy_nxt;
  logic [LENGTH_WIDTH-1:0]     tick_r, tick_nxt;
  logic [LENGTH_WIDTH-1:0]     period_r, period_nxt;
  logic                        level_r, level_nxt;
  tpp_pkg::long_phase_t        phase_r, phase_nxt;
  logic [tpp_pkg::BYTE_W-1:0]  lb0_r, lb0_nxt;
  logic [tpp_pkg::BYTE_W-1:0]  lb1_r, lb1_nxt;
  logic [LENGTH_WIDTH-1:0]     tick_inc;
  logic [LENGTH_WIDTH-1:0]     scaled_len;
  logic                        taken;
  logic                        ended;

  tpp_scale #(
    .LENGTH_WIDTH(LENGTH_WIDTH)
  ) u_scale (
    .long_sel   (phase_r == tpp_pkg::LF_LAST),
    .data_byte  (data_byte),
    .long_byte0 (lb0_r),
    .long_byte1 (lb1_r),
    .short_scale(short_scale),
    .long_scale (long_scale),
    .period     (scaled_len)
  );

  always_comb begin
    busy_nxt   = busy_r;
    tick_nxt   = tick_r;
    period_nxt = period_r;
    level_nxt  = level_r;
    phase_nxt  = phase_r;
    lb0_nxt    = lb0_r;
    lb1_nxt    = lb1_r;
    taken      = 1'b0;
    ended      = 1'b0;
    // count stops at all ones
    tick_inc   = (&tick_r) ? tick_r : tick_r + 1'b1;

    if (busy_r) begin
      tick_nxt = tick_inc;
      if (tick_inc >= (period_r >> 1)) begin
        level_nxt = 1'b1;
      end
      if (tick_inc >= period_r) begin
        ended     = 1'b1;
        level_nxt = 1'b0;
        busy_nxt  = 1'b0;
      end
    end else if (motor_on && data_valid) begin
      taken = 1'b1;
      case (phase_r)
        tpp_pkg::LF_FIRST: begin
          lb0_nxt   = data_byte;
          phase_nxt = tpp_pkg::LF_MID;
        end
        tpp_pkg::LF_MID: begin
          lb1_nxt   = data_byte;
          phase_nxt = tpp_pkg::LF_LAST;
        end
        tpp_pkg::LF_LAST: begin
          phase_nxt  = tpp_pkg::LF_NONE;
          period_nxt = scaled_len;
          tick_nxt   = '0;
          busy_nxt   = 1'b1;
          level_nxt  = 1'b0;
        end
        default: begin
          if (data_byte == '0) begin
            phase_nxt = tpp_pkg::LF_FIRST;
          end else begin
            period_nxt = scaled_len;
            tick_nxt   = '0;
            busy_nxt   = 1'b1;
            level_nxt  = 1'b0;
          end
        end
      endcase
    end

    res.read_level = level_nxt;
    res.byte_taken = taken;
    res.pulse_end  = ended;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      tick_r   <= '0;
      period_r <= '0;
      level_r  <= 1'b0;
      phase_r  <= tpp_pkg::LF_NONE;
    end else if (step) begin
      busy_r   <= busy_nxt;
      tick_r   <= tick_nxt;
      period_r <= period_nxt;
      level_r  <= level_nxt;
      phase_r  <= phase_nxt;
    end
  end

  // long-form bytes are always written before use
  always_ff @(posedge clk) begin
    if (step) begin
      lb0_r <= lb0_nxt;
      lb1_r <= lb1_nxt;
    end
  end

endmodule

>>> sv/tape_pulse_playback_top.sv
// tape pulse playback top level: config registers, input stage, result register
//
// channel  direction  ports
// in       input      in_valid/in_ready, in_motor_on, in_data_valid, in_data_byte
// out      output     out_valid/out_ready, out_read_level, out_byte_taken, out_pulse_end
// cfg      input      cfg_valid/cfg_ready, cfg_index, cfg_data
//
// one item per clock sustained while out_ready stays high; each item is held in the input
// register and is processed into the result register when that register is empty or being drained
// an accepted item passes through the input register, then the result register, to result valid
// the pulse state advances only when an item moves from input to result register
// a stalled result register holds the input stage, then in_ready drops
// rst_n is synchronous; scales return to their defaults, no item is held
module tape_pulse_playback_top #(
  parameter int LENGTH_WIDTH = tpp_pkg::LENGTH_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_motor_on,
  input  logic                             in_data_valid,
  input  logic [tpp_pkg::BYTE_W-1:0]       in_data_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_read_level,
  output logic                             out_byte_taken,
  output logic                             out_pulse_end,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tpp_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [tpp_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [tpp_pkg::SHORT_SCALE_W-1:0] short_scale_r;
  logic [tpp_pkg::LONG_SCALE_W-1:0]  long_scale_r;
  logic                              s1_valid_r;
  logic                              s1_motor_r;
  logic                              s1_dvalid_r;
  logic [tpp_pkg::BYTE_W-1:0]        s1_byte_r;
  logic                              out_valid_r;
  tpp_pkg::tpp_result_t              out_res_r;
  tpp_pkg::tpp_result_t              res;
  logic                              advance;
  logic                              in_fire;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_scale_r <= tpp_pkg::SHORT_SCALE_RST;
      long_scale_r  <= tpp_pkg::LONG_SCALE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        tpp_pkg::CFG_SHORT_SCALE: short_scale_r <= cfg_data;
        tpp_pkg::CFG_LONG_SCALE:  long_scale_r  <= cfg_data[tpp_pkg::LONG_SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // item moves on when the result register is empty or being drained
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_motor_r  <= in_motor_on;
      s1_dvalid_r <= in_data_valid;
      s1_byte_r   <= in_data_byte;
    end
  end

  tpp_pulse #(
    .LENGTH_WIDTH(LENGTH_WIDTH)
  ) u_pulse (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .motor_on   (s1_motor_r),
    .data_valid (s1_dvalid_r),
    .data_byte  (s1_byte_r),
    .short_scale(short_scale_r),
    .long_scale (long_scale_r),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_level = out_res_r.read_level;
  assign out_byte_taken = out_res_r.byte_taken;
  assign out_pulse_end  = out_res_r.pulse_end;

endmodule

>>> sv/tpp_checker.sv
// port-level checks for the tape pulse playback block, bound to the top level
module tpp_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic out_read_level,
  input logic out_byte_taken,
  input logic out_pulse_end
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_level)
      && $stable(out_byte_taken) && $stable(out_pulse_end))
    else $error("result changed while stalled");

  // a byte is never taken on the tick a pulse ends
  a_take_vs_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_byte_taken && out_pulse_end))
    else $error("byte taken on pulse end");

  // line returns low when a pulse ends
  a_end_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pulse_end |-> !out_read_level)
    else $error("line high at pulse end");

  // bytes are only taken while idle, so the line is low
  a_take_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_taken |-> !out_read_level)
    else $error("line high when byte taken");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind tape_pulse_playback_top tpp_checker u_tpp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_read_level(out_read_level),
  .out_byte_taken(out_byte_taken),
  .out_pulse_end (out_pulse_end)
);
